### hdl/uved_pkg.sv
// Shared widths, register indexes, reset values and handshake structs for the
// undervoltage episode detector. Depends on nothing; uved_dp, uved_ctrl and the top level import it.
package uved_pkg;

    localparam int TIME_W    = 44;
    localparam int VOLT_W    = 18;
    localparam int SAMPLES_W = 16;
    localparam int CFG_W     = 44;
    localparam int CFG_IDX_W = 2;

    localparam int COUNT_BITS_DEFAULT = 16;
    localparam int VOLT_BITS_DEFAULT  = 18;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DURATION = 2'd1;

    localparam logic [VOLT_W-1:0] THRESHOLD_RESET    = 18'd155000;
    localparam logic [TIME_W-1:0] MIN_DURATION_RESET = 44'd3000;
    localparam logic [TIME_W-1:0] FAR_END            = 44'd9999999999999;

    typedef struct packed {
        logic accept;
        logic div_start;
        logic load_out;
    } uved_cmd_t;

    typedef struct packed {
        logic emit;
        logic div_done;
    } uved_stat_t;

endpackage

### hdl/uved_div.sv
// Restoring serial divider, one quotient bit per cycle, for the episode mean.
// Depends on nothing outside this file.
module uved_div #(
    parameter int DIVIDEND_W = 34,
    parameter int DIVISOR_W  = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  ack,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic [DIVIDEND_W-1:0] quotient,
    output logic                  done
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] quot_reg, quot_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dvs_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg;
    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;

    always_comb
    begin
        shifted   = {rem_reg, quot_reg[DIVIDEND_W-1]};
        diff      = shifted - {1'b0, dvs_reg};
        fits      = (shifted >= {1'b0, dvs_reg});
        rem_next  = fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
        quot_next = {quot_reg[DIVIDEND_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            quot_reg <= '0;
            rem_reg  <= '0;
            dvs_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(DIVIDEND_W);
            quot_reg <= dividend;
            rem_reg  <= '0;
            dvs_reg  <= divisor;
        end
        else
        begin
            if (ack)
            begin
                busy_reg <= 1'b0;
            end
            if (busy_reg && (cnt_reg != '0))
            begin
                cnt_reg  <= cnt_reg - 1'b1;
                quot_reg <= quot_next;
                rem_reg  <= rem_next;
            end
        end
    end

    assign quotient = quot_reg;
    assign done     = busy_reg && (cnt_reg == '0);

endmodule

### hdl/uved_dp.sv
// Datapath: configuration registers, open-episode state, result snapshot, mean
// divider and output word register. Depends on uved_pkg and uved_div.
module uved_dp #(
    parameter int COUNT_BITS = uved_pkg::COUNT_BITS_DEFAULT,
    parameter int VOLT_BITS  = uved_pkg::VOLT_BITS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  uved_pkg::uved_cmd_t              cmd,
    output uved_pkg::uved_stat_t             stat,
    input  logic                             cfg_write,
    input  logic [uved_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [uved_pkg::CFG_W-1:0]       cfg_data,
    input  logic [uved_pkg::TIME_W-1:0]      sample_time,
    input  logic [uved_pkg::VOLT_W-1:0]      sample_voltage,
    input  logic                             object_end,
    output logic [uved_pkg::TIME_W-1:0]      episode_start,
    output logic [uved_pkg::TIME_W-1:0]      episode_end,
    output logic [uved_pkg::VOLT_W-1:0]      mean_voltage,
    output logic [uved_pkg::VOLT_W-1:0]      min_voltage,
    output logic [uved_pkg::SAMPLES_W-1:0]   episode_samples,
    output logic                             open_ended
);

    import uved_pkg::*;

    // Sample voltages are held to the narrower of the port and VOLT_BITS.
    localparam int VW    = (VOLT_BITS < VOLT_W) ? VOLT_BITS : VOLT_W;
    localparam int SUM_W = VW + COUNT_BITS;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic [VOLT_W-1:0]     thr_reg;
    logic [TIME_W-1:0]     min_dur_reg;

    logic                  in_ep_reg;
    logic                  at_start_reg;
    logic [TIME_W-1:0]     start_reg;
    logic [SUM_W-1:0]      sum_reg;
    logic [VOLT_W-1:0]     low_reg;
    logic [COUNT_BITS-1:0] tally_reg;

    logic [TIME_W-1:0]     res_start_reg;
    logic [TIME_W-1:0]     res_end_reg;
    logic [VOLT_W-1:0]     res_low_reg;
    logic [COUNT_BITS-1:0] res_tally_reg;
    logic                  res_open_reg;

    logic [TIME_W-1:0]     out_start_reg;
    logic [TIME_W-1:0]     out_end_reg;
    logic [VOLT_W-1:0]     out_mean_reg;
    logic [VOLT_W-1:0]     out_low_reg;
    logic [SAMPLES_W-1:0]  out_samples_reg;
    logic                  out_open_reg;

    logic [VOLT_W-1:0]     v_in;
    logic                  issue;
    logic                  close;
    logic                  flush_cand;
    logic                  long_ok;
    logic                  in_after;
    logic [TIME_W-1:0]     st_after;
    logic [TIME_W-1:0]     en_after;
    logic [TIME_W-1:0]     ls;
    logic [TIME_W-1:0]     le;
    logic [SUM_W-1:0]      sum_after;
    logic [VOLT_W-1:0]     low_after;
    logic [COUNT_BITS-1:0] tally_after;
    logic [SUM_W-1:0]      quotient;

    assign v_in = VOLT_W'(VW'(sample_voltage));

    always_comb
    begin
        issue       = (v_in < thr_reg);
        close       = !issue && in_ep_reg;
        in_after    = in_ep_reg;
        st_after    = start_reg;
        en_after    = sample_time;
        sum_after   = sum_reg;
        low_after   = low_reg;
        tally_after = tally_reg;
        if (issue && !in_ep_reg)
        begin
            in_after    = 1'b1;
            st_after    = at_start_reg ? '0 : sample_time;
            en_after    = st_after;
            sum_after   = SUM_W'(v_in);
            low_after   = v_in;
            tally_after = COUNT_BITS'(1);
        end
        else if (issue)
        begin
            if (v_in < low_reg)
            begin
                low_after = v_in;
            end
            if (tally_reg != COUNT_MAX)
            begin
                sum_after   = sum_reg + SUM_W'(v_in);
                tally_after = tally_reg + 1'b1;
            end
        end
        else if (close)
        begin
            in_after = 1'b0;
        end
        // An episode that still stands at object end is flushed only when its
        // start and end differ, and never when this sample closed it.
        flush_cand = object_end && in_after && (st_after != en_after);
        ls         = close ? start_reg : st_after;
        le         = close ? sample_time : FAR_END;
        // A reversed time order counts as long enough.
        long_ok    = (le < ls) || ((le - ls) >= min_dur_reg);
    end

    assign stat.emit = (close || flush_cand) && long_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg     <= THRESHOLD_RESET;
            min_dur_reg <= MIN_DURATION_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_THRESHOLD:    thr_reg     <= cfg_data[VOLT_W-1:0];
                REG_MIN_DURATION: min_dur_reg <= cfg_data[TIME_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ep_reg    <= 1'b0;
            at_start_reg <= 1'b1;
            start_reg    <= '0;
            sum_reg      <= '0;
            low_reg      <= '0;
            tally_reg    <= '0;
        end
        else if (cmd.accept)
        begin
            start_reg    <= st_after;
            at_start_reg <= object_end;
            if (close || object_end)
            begin
                in_ep_reg <= 1'b0;
                sum_reg   <= '0;
                low_reg   <= '0;
                tally_reg <= '0;
            end
            else
            begin
                in_ep_reg <= in_after;
                sum_reg   <= sum_after;
                low_reg   <= low_after;
                tally_reg <= tally_after;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            res_start_reg <= st_after;
            res_end_reg   <= close ? sample_time : FAR_END;
            res_low_reg   <= low_after;
            res_tally_reg <= tally_after;
            res_open_reg  <= !close;
        end
        if (cmd.load_out)
        begin
            out_start_reg   <= res_start_reg;
            out_end_reg     <= res_end_reg;
            out_mean_reg    <= VOLT_W'(quotient);
            out_low_reg     <= res_low_reg;
            out_samples_reg <= SAMPLES_W'(res_tally_reg);
            out_open_reg    <= res_open_reg;
        end
    end

    uved_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (COUNT_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .ack      (cmd.load_out),
        .dividend (sum_after),
        .divisor  (tally_after),
        .quotient (quotient),
        .done     (stat.div_done)
    );

    assign episode_start   = out_start_reg;
    assign episode_end     = out_end_reg;
    assign mean_voltage    = out_mean_reg;
    assign min_voltage     = out_low_reg;
    assign episode_samples = out_samples_reg;
    assign open_ended      = out_open_reg;

endmodule

### hdl/uved_ctrl.sv
// Controller: takes samples, waits on the mean divider and hands the finished
// word to the output register. Depends on uved_pkg.
module uved_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  uved_pkg::uved_stat_t stat,
    output uved_pkg::uved_cmd_t  cmd
);

    import uved_pkg::*;

    typedef enum logic {
        IDLE,
        DIVIDE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        cmd.accept     = (state_reg == IDLE) && in_valid;
        cmd.div_start  = cmd.accept && stat.emit;
        cmd.load_out   = 1'b0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            IDLE:
            begin
                if (cmd.div_start)
                begin
                    state_next = DIVIDE;
                end
            end
            DIVIDE:
            begin
                // The new word may replace one that is being taken this cycle.
                if (stat.div_done && (!out_valid_reg || out_ready))
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == IDLE);
    assign out_valid = out_valid_reg;

endmodule

### hdl/undervoltage_episode_detector.sv
// Undervoltage episode detector. A sample that yields no episode does not hold off
// input. A sample that yields an episode holds off input while the serial mean
// divider runs, plus any output stall. The word appears in the output register as
// input is taken again. Reset is asynchronous and active low: control, episode,
// configuration and divider registers return to their defaults (result and output
// words are not reset), no episode is open and the next sample starts an object.
module undervoltage_episode_detector #(
    parameter int COUNT_BITS = uved_pkg::COUNT_BITS_DEFAULT,
    parameter int VOLT_BITS  = uved_pkg::VOLT_BITS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [uved_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [uved_pkg::CFG_W-1:0]       cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [uved_pkg::TIME_W-1:0]      sample_time,
    input  logic [uved_pkg::VOLT_W-1:0]      sample_voltage,
    input  logic                             object_end,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [uved_pkg::TIME_W-1:0]      episode_start,
    output logic [uved_pkg::TIME_W-1:0]      episode_end,
    output logic [uved_pkg::VOLT_W-1:0]      mean_voltage,
    output logic [uved_pkg::VOLT_W-1:0]      min_voltage,
    output logic [uved_pkg::SAMPLES_W-1:0]   episode_samples,
    output logic                             open_ended
);

    import uved_pkg::*;

    uved_cmd_t  cmd;
    uved_stat_t stat;

    uved_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    uved_dp #(
        .COUNT_BITS (COUNT_BITS),
        .VOLT_BITS  (VOLT_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .sample_time     (sample_time),
        .sample_voltage  (sample_voltage),
        .object_end      (object_end),
        .episode_start   (episode_start),
        .episode_end     (episode_end),
        .mean_voltage    (mean_voltage),
        .min_voltage     (min_voltage),
        .episode_samples (episode_samples),
        .open_ended      (open_ended)
    );

    // Input is held off from the cycle after an episode starts its division.
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> !in_ready)
        else $error("input taken while the mean is being divided");

    // A word goes to the output register only once its quotient is complete.
    a_load_when_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> stat.div_done)
        else $error("output loaded before the division finished");

    // Loading the output register always raises out_valid.
    a_valid_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> out_valid)
        else $error("loaded word not offered on the output");

    // While input is taken, no finished quotient is left waiting.
    a_no_stale_quotient: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !stat.div_done)
        else $error("finished quotient left behind while idle");

endmodule
